FILE: rtl/core/eul2rm_pkg.sv
package eul2rm_pkg;

    // Angle units: 1/64 degree
    localparam int TURN_UNITS    = 23040;
    localparam int HALF_UNITS    = 11520;
    localparam int QUARTER_UNITS = 5760;
    localparam int TRIPLE_UNITS  = 17280;

    // Radian conversion: theta = floor(u * PI_Q30 / 11520), done as (>> 8) then / 45
    localparam logic [31:0] PI_Q30     = 32'd3373259426;
    localparam logic [30:0] ONE_Q30    = 31'd1073741824;
    localparam logic [5:0]  THETA_DIV  = 6'd45;
    localparam logic [31:0] THETA_RECIP = 32'((64'd1 << 37) / 64'd45);

    // Horner steps of the sine series, one constant divisor each
    localparam int HORNER_STEPS = 6;
    localparam logic [7:0] HORNER_DIV [HORNER_STEPS] =
        '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [31:0] HORNER_RECIP [HORNER_STEPS] = '{
        32'((64'd1 << 32) / 64'd156),
        32'((64'd1 << 32) / 64'd110),
        32'((64'd1 << 32) / 64'd72),
        32'((64'd1 << 32) / 64'd42),
        32'((64'd1 << 32) / 64'd20),
        32'((64'd1 << 32) / 64'd6)
    };

    // Register stages from request to result
    localparam int PIPE_DEPTH = 29;

    typedef logic [12:0] quarter_t;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
    } angles_t;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } matrix_t;

    // Fold a point of one turn into the first quadrant with a sign
    typedef struct packed {
        logic     neg;
        quarter_t u;
    } fold_t;

    function automatic fold_t fold_turn(input logic [14:0] m);
        fold_t f;
        if (m < 15'(QUARTER_UNITS))
        begin
            f.neg = 1'b0;
            f.u   = m[12:0];
        end
        else if (m < 15'(HALF_UNITS))
        begin
            f.neg = 1'b0;
            f.u   = 13'(15'(HALF_UNITS) - m);
        end
        else if (m < 15'(TRIPLE_UNITS))
        begin
            f.neg = 1'b1;
            f.u   = 13'(m - 15'(HALF_UNITS));
        end
        else
        begin
            f.neg = 1'b1;
            f.u   = 13'(15'(TURN_UNITS) - m);
        end
        return f;
    endfunction

endpackage

FILE: rtl/core/euler_angles_to_rotation_matrix.sv
// ZYX Euler angles to rotation matrix R = Rz(yaw)*Ry(pitch)*Rx(roll), entries in Q1.15.
// Angles are 1/64 degree and wrap modulo one turn. Fully pipelined: one request is
// taken per clock while the result side keeps up, and each request passes the wrap,
// fold, sine and matrix stages in order. Six quarter-wave sine pipelines (Taylor
// series in Horner form, one stage per multiply, divide estimate and correction)
// make up most of that path; a stall on the result side holds the whole pipeline.
module euler_angles_to_rotation_matrix
    import eul2rm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    angles_valid,
    output logic    angles_ready,
    input  angles_t angles,
    output logic    matrix_valid,
    input  logic    matrix_ready,
    output matrix_t matrix
);

    logic en;
    logic [PIPE_DEPTH-1:0] vld_reg;

    assign en           = !vld_reg[PIPE_DEPTH-1] || matrix_ready;
    assign angles_ready = en;
    assign matrix_valid = vld_reg[PIPE_DEPTH-1];

    // Valid bits alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], angles_valid};
        end
    end

    // Reduce an angle into one turn
    function automatic logic [14:0] wrap_turn(input logic signed [15:0] a);
        logic signed [17:0] w;
        w = 18'(a);
        if (w < 0)
        begin
            w = (w >= -18'sd23040) ? w + 18'sd23040 : w + 18'sd46080;
        end
        else if (w >= 18'sd23040)
        begin
            w = w - 18'sd23040;
        end
        return w[14:0];
    endfunction

    function automatic logic [14:0] add_quarter(input logic [14:0] m);
        logic [15:0] s;
        s = 16'(m) + 16'(QUARTER_UNITS);
        if (s >= 16'(TURN_UNITS))
        begin
            s = s - 16'(TURN_UNITS);
        end
        return s[14:0];
    endfunction

    // Stage R1: wrap
    logic [14:0] m_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0] <= wrap_turn(angles.roll_angle);
            m_reg[1] <= wrap_turn(angles.pitch_angle);
            m_reg[2] <= wrap_turn(angles.yaw_angle);
        end
    end

    // Stage R2: fold for sine and cosine, then the sine pipelines
    fold_t sf_reg [3];
    fold_t cf_reg [3];
    logic signed [15:0] sn [3];
    logic signed [15:0] cs [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sf_reg[k] <= fold_turn(m_reg[k]);
                cf_reg[k] <= fold_turn(add_quarter(m_reg[k]));
            end
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_trig
        eul2rm_sine u_sin (
            .clk  (clk),
            .en   (en),
            .u    (sf_reg[k].u),
            .neg  (sf_reg[k].neg),
            .sine (sn[k])
        );

        eul2rm_sine u_cos (
            .clk  (clk),
            .en   (en),
            .u    (cf_reg[k].u),
            .neg  (cf_reg[k].neg),
            .sine (cs[k])
        );
    end

    logic signed [15:0] sr, cr, sp, cp, sy, cy;

    assign sr = sn[0];
    assign cr = cs[0];
    assign sp = sn[1];
    assign cp = cs[1];
    assign sy = sn[2];
    assign cy = cs[2];

    // Stage M1: two-factor products, Q2.30
    logic signed [31:0] cy_cp_reg, sy_cp_reg, cp_sr_reg, cp_cr_reg, sy_cr_reg;
    logic signed [31:0] sy_sr_reg, cy_cr_reg, cy_sr_reg, sp_sr_reg, sp_cr_reg;
    logic signed [15:0] cy_reg, sy_reg, sp_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cy_cp_reg <= 32'(cy) * 32'(cp);
            sy_cp_reg <= 32'(sy) * 32'(cp);
            cp_sr_reg <= 32'(cp) * 32'(sr);
            cp_cr_reg <= 32'(cp) * 32'(cr);
            sy_cr_reg <= 32'(sy) * 32'(cr);
            sy_sr_reg <= 32'(sy) * 32'(sr);
            cy_cr_reg <= 32'(cy) * 32'(cr);
            cy_sr_reg <= 32'(cy) * 32'(sr);
            sp_sr_reg <= 32'(sp) * 32'(sr);
            sp_cr_reg <= 32'(sp) * 32'(cr);
            cy_reg    <= cy;
            sy_reg    <= sy;
            sp_reg    <= sp;
        end
    end

    // Stage M2: entries summed in Q3.45
    logic signed [47:0] e_reg [9];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg[0] <= 48'(cy_cp_reg) <<< 15;
            e_reg[1] <= 48'(cy_reg) * 48'(sp_sr_reg) - (48'(sy_cr_reg) <<< 15);
            e_reg[2] <= 48'(cy_reg) * 48'(sp_cr_reg) + (48'(sy_sr_reg) <<< 15);
            e_reg[3] <= 48'(sy_cp_reg) <<< 15;
            e_reg[4] <= 48'(sy_reg) * 48'(sp_sr_reg) + (48'(cy_cr_reg) <<< 15);
            e_reg[5] <= 48'(sy_reg) * 48'(sp_cr_reg) - (48'(cy_sr_reg) <<< 15);
            e_reg[6] <= -(48'(sp_reg) <<< 30);
            e_reg[7] <= 48'(cp_sr_reg) <<< 15;
            e_reg[8] <= 48'(cp_cr_reg) <<< 15;
        end
    end

    // Stage M3: round half up to Q1.15 and saturate
    function automatic logic signed [15:0] to_q15(input logic signed [47:0] v);
        logic signed [47:0] w;
        logic signed [17:0] r;
        w = v + 48'sd536870912;
        r = 18'(w >>> 30);
        if (r > 18'sd32767)
        begin
            return 16'sd32767;
        end
        else if (r < -18'sd32768)
        begin
            return -16'sd32768;
        end
        return r[15:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            matrix.m00 <= to_q15(e_reg[0]);
            matrix.m01 <= to_q15(e_reg[1]);
            matrix.m02 <= to_q15(e_reg[2]);
            matrix.m10 <= to_q15(e_reg[3]);
            matrix.m11 <= to_q15(e_reg[4]);
            matrix.m12 <= to_q15(e_reg[5]);
            matrix.m20 <= to_q15(e_reg[6]);
            matrix.m21 <= to_q15(e_reg[7]);
            matrix.m22 <= to_q15(e_reg[8]);
        end
    end

endmodule

FILE: rtl/core/eul2rm_sine.sv
// Quarter-wave sine in Q1.15; every register advances only while en is high
module eul2rm_sine
    import eul2rm_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  quarter_t           u,
    input  logic               neg,
    output logic signed [15:0] sine
);

    localparam int CARRY = 3 * HORNER_STEPS;

    // Stage A: u * pi
    logic [44:0] a_v_reg;
    logic        a_neg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_v_reg   <= 45'(u) * 45'(PI_Q30);
            a_neg_reg <= neg;
        end
    end

    // Stage B: estimate quotient by 45
    logic [68:0] b_prod;
    logic [30:0] b_qe_reg;
    logic [36:0] b_w_reg;
    logic        b_neg_reg;

    assign b_prod = 69'(a_v_reg[44:8]) * 69'(THETA_RECIP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_qe_reg  <= b_prod[67:37];
            b_w_reg   <= a_v_reg[44:8];
            b_neg_reg <= a_neg_reg;
        end
    end

    // Stage C: one-step quotient correction
    logic [36:0] c_rem;
    logic [30:0] c_theta_reg;
    logic        c_neg_reg;

    assign c_rem = b_w_reg - 37'(b_qe_reg) * 37'(THETA_DIV);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_theta_reg <= b_qe_reg + 31'(c_rem >= 37'(THETA_DIV));
            c_neg_reg   <= b_neg_reg;
        end
    end

    // Stage D: theta squared
    logic [61:0] d_sq;
    logic [31:0] x2_reg    [CARRY - 2];
    logic [30:0] theta_reg [CARRY + 1];
    logic        neg_reg   [CARRY + 1];

    assign d_sq = 62'(c_theta_reg) * 62'(c_theta_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2_reg[0]    <= d_sq[61:30];
            theta_reg[0] <= c_theta_reg;
            neg_reg[0]   <= c_neg_reg;
        end
    end

    // Side carry of x2, theta and sign through the Horner stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 1; j < CARRY - 2; j++)
            begin
                x2_reg[j] <= x2_reg[j - 1];
            end
            for (int j = 1; j <= CARRY; j++)
            begin
                theta_reg[j] <= theta_reg[j - 1];
                neg_reg[j]   <= neg_reg[j - 1];
            end
        end
    end

    // Horner steps: multiply, divide estimate, correct and subtract
    logic [30:0] t_in    [HORNER_STEPS];
    logic [31:0] p_reg   [HORNER_STEPS];
    logic [31:0] pf_reg  [HORNER_STEPS];
    logic [31:0] qe_reg  [HORNER_STEPS];
    logic [30:0] t_reg   [HORNER_STEPS];

    assign t_in[0] = ONE_Q30;

    for (genvar i = 0; i < HORNER_STEPS; i++)
    begin : g_horner
        logic [62:0] prod;
        logic [63:0] est;
        logic [31:0] rem;
        logic [31:0] quo;

        assign prod = 63'(x2_reg[3 * i]) * 63'(t_in[i]);
        assign est  = 64'(p_reg[i]) * 64'(HORNER_RECIP[i]);
        assign rem  = pf_reg[i] - qe_reg[i] * 32'(HORNER_DIV[i]);
        assign quo  = qe_reg[i] + 32'(rem >= 32'(HORNER_DIV[i]));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[i]  <= prod[61:30];
                qe_reg[i] <= est[63:32];
                pf_reg[i] <= p_reg[i];
                t_reg[i]  <= ONE_Q30 - quo[30:0];
            end
        end

        if (i + 1 < HORNER_STEPS)
        begin : g_link
            assign t_in[i + 1] = t_reg[i];
        end
    end

    // Stage H: theta * series
    logic [61:0] h_prod;
    logic [31:0] h_s_reg;
    logic        h_neg_reg;

    assign h_prod = 62'(theta_reg[CARRY]) * 62'(t_reg[HORNER_STEPS - 1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_s_reg   <= h_prod[61:30];
            h_neg_reg <= neg_reg[CARRY];
        end
    end

    // Stage I: round to Q1.15, saturate, apply sign
    logic [32:0] i_round;
    logic [15:0] i_mag;

    assign i_round = (33'(h_s_reg) + 33'd16384) >> 15;
    assign i_mag   = (i_round > 33'd32767) ? 16'd32767 : i_round[15:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sine <= h_neg_reg ? -$signed(i_mag) : $signed(i_mag);
        end
    end

endmodule

FILE: bench/rotation_matrix_checker.sv
module rotation_matrix_checker
    import eul2rm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    angles_valid,
    input  logic    angles_ready,
    input  angles_t angles,
    input  logic    matrix_valid,
    input  logic    matrix_ready,
    input  matrix_t matrix,
    output int      errors,
    output int      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    matrix_t expected_matrices[$];

    // sine of u/64 degrees, u within the first quadrant, Q1.15
    function automatic longint quadrant_sine(input longint unsigned u);
        longint unsigned divisor [6] = '{156, 110, 72, 42, 20, 6};
        longint unsigned theta;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        theta = (u * 64'd3373259426) / 64'd11520;
        x2    = (theta * theta) >> 30;
        t     = 64'd1 << 30;
        for (int i = 0; i < 6; i++)
            t = (64'd1 << 30) - (((x2 * t) >> 30) / divisor[i]);
        s = (theta * t) >> 30;
        s = (s + 64'd16384) >> 15;
        if (s > 64'd32767)
            s = 64'd32767;
        return longint'(s);
    endfunction

    // sine of a point of one turn (0..23039)
    function automatic longint turn_sine(input int m);
        int q;
        int r;
        q = m / QUARTER_UNITS;
        r = m % QUARTER_UNITS;
        case (q)
            0: return quadrant_sine(r);
            1: return quadrant_sine(QUARTER_UNITS - r);
            2: return -quadrant_sine(r);
            default: return -quadrant_sine(QUARTER_UNITS - r);
        endcase
    endfunction

    // Q3.45 sum to Q1.15, half up, saturating
    function automatic logic signed [15:0] q45_to_q15(input longint v);
        longint r;
        r = (v + (64'sd1 <<< 29)) >>> 30;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return 16'(r);
    endfunction

    function automatic matrix_t rotation_of(input angles_t a);
        longint sr, cr, sp, cp, sy, cy;
        longint k;
        int m [3];
        longint s [3];
        longint c [3];
        matrix_t e;
        k = 32768;
        m[0] = int'(a.roll_angle) % TURN_UNITS;
        m[1] = int'(a.pitch_angle) % TURN_UNITS;
        m[2] = int'(a.yaw_angle) % TURN_UNITS;
        for (int i = 0; i < 3; i++)
        begin
            if (m[i] < 0)
                m[i] += TURN_UNITS;
            s[i] = turn_sine(m[i]);
            c[i] = turn_sine((m[i] + QUARTER_UNITS) % TURN_UNITS);
        end
        sr = s[0]; cr = c[0];
        sp = s[1]; cp = c[1];
        sy = s[2]; cy = c[2];
        e.m00 = q45_to_q15(cy * cp * k);
        e.m01 = q45_to_q15(cy * sp * sr - sy * cr * k);
        e.m02 = q45_to_q15(cy * sp * cr + sy * sr * k);
        e.m10 = q45_to_q15(sy * cp * k);
        e.m11 = q45_to_q15(sy * sp * sr + cy * cr * k);
        e.m12 = q45_to_q15(sy * sp * cr - cy * sr * k);
        e.m20 = q45_to_q15(-sp * k * k);
        e.m21 = q45_to_q15(cp * sr * k);
        e.m22 = q45_to_q15(cp * cr * k);
        return e;
    endfunction

    function automatic int diff(input string name, input logic signed [15:0] exp_v,
                                input logic signed [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    // record requests and compare results in order
    always @(posedge clk)
    begin
        matrix_t e;
        if (!rst_n)
        begin
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (angles_valid && angles_ready)
                expected_matrices.push_back(rotation_of(angles));
            if (matrix_valid && matrix_ready)
            begin
                if (expected_matrices.size() == 0)
                begin
                    $error("result with no request outstanding");
                    errors++;
                end
                else
                begin
                    e = expected_matrices.pop_front();
                    errors += diff("m00", e.m00, matrix.m00);
                    errors += diff("m01", e.m01, matrix.m01);
                    errors += diff("m02", e.m02, matrix.m02);
                    errors += diff("m10", e.m10, matrix.m10);
                    errors += diff("m11", e.m11, matrix.m11);
                    errors += diff("m12", e.m12, matrix.m12);
                    errors += diff("m20", e.m20, matrix.m20);
                    errors += diff("m21", e.m21, matrix.m21);
                    errors += diff("m22", e.m22, matrix.m22);
                end
            end
            pending = expected_matrices.size();
        end
    end
endmodule

FILE: bench/tb.sv
module tb;
    import eul2rm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 880;
    localparam int STALL_LIMIT     = 5000;

    logic    clk;
    logic    rst_n;
    logic    angles_valid;
    logic    angles_ready;
    angles_t angles;
    logic    matrix_valid;
    logic    matrix_ready;
    matrix_t matrix;
    int      errors;
    int      pending;
    int      sent;
    int      idle_cycles;
    bit      long_hold_done;

    euler_angles_to_rotation_matrix u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .angles_valid (angles_valid),
        .angles_ready (angles_ready),
        .angles       (angles),
        .matrix_valid (matrix_valid),
        .matrix_ready (matrix_ready),
        .matrix       (matrix)
    );

    rotation_matrix_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .angles_valid (angles_valid),
        .angles_ready (angles_ready),
        .angles       (angles),
        .matrix_valid (matrix_valid),
        .matrix_ready (matrix_ready),
        .matrix       (matrix),
        .errors       (errors),
        .pending      (pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [15:0] random_angle();
        if ($urandom_range(0, 9) < 8)
            return 16'($signed($urandom_range(0, 46080)) - 23040);
        return 16'($urandom);
    endfunction

    task automatic send_request(input logic signed [15:0] r, input logic signed [15:0] p,
                                input logic signed [15:0] y, input bit gaps);
        int g;
        angles_valid <= 1'b1;
        angles       <= '{roll_angle: r, pitch_angle: p, yaw_angle: y};
        do
            @(posedge clk);
        while (!angles_ready);
        sent++;
        g = gaps ? gap_length() : 0;
        if (g > 0)
        begin
            angles_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // result side: random stalls, one long hold-off once the pipe is busy
    initial
    begin
        int g;
        matrix_ready   = 1'b0;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && sent > 300)
            begin
                long_hold_done = 1'b1;
                matrix_ready <= 1'b0;
                repeat (200) @(posedge clk);
            end
            else if (sent > 100 && sent < 250)
                matrix_ready <= 1'b1;
            else
            begin
                g = gap_length();
                if (g > 0)
                begin
                    matrix_ready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
                matrix_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((angles_valid && angles_ready) || (matrix_valid && matrix_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        logic signed [15:0] corner [12];
        corner = '{16'sd0, 16'sd23040, -16'sd23040, 16'sd5760, -16'sd5760, 16'sd11520,
                   16'sd17280, 16'sd2880, 16'sd32767, -16'sd32768, 16'sd1, -16'sd1};
        sent         = 0;
        rst_n        = 1'b0;
        angles_valid = 1'b0;
        angles       = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: each corner on each axis, then mixed
        for (int i = 0; i < 12; i++)
            send_request(corner[i], corner[(i + 3) % 12], corner[(i + 7) % 12], 1'b0);
        send_request(16'sd5760, 16'sd5760, 16'sd5760, 1'b1);
        send_request(-16'sd5760, -16'sd5760, -16'sd5760, 1'b1);
        send_request(16'sd11520, 16'sd0, 16'sd5760, 1'b1);
        send_request(16'sd2880, 16'sd2880, 16'sd2880, 1'b0);
        send_request(16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
        send_request(-16'sd32768, -16'sd32768, -16'sd32768, 1'b1);
        send_request(16'sd17280, 16'sd11520, -16'sd11520, 1'b0);
        send_request(16'sd5759, 16'sd5761, 16'sd11519, 1'b1);

        // random angles, with one full drain part way through
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i == 500)
            begin
                angles_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending != 0);
            end
            send_request(random_angle(), random_angle(), random_angle(),
                         !(sent > 100 && sent < 400));
        end
        angles_valid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/core/eul2rm_pkg.sv
rtl/core/eul2rm_sine.sv
rtl/core/euler_angles_to_rotation_matrix.sv
bench/rotation_matrix_checker.sv
bench/tb.sv
